>>> hdl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types and constants for the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

   localparam int QW = 16;   // quaternion component width
   localparam int AW = 16;   // output angle width
   localparam int TW = 34;   // product term width, Q28
   localparam int VW = 58;   // root operand width
   localparam int RW = 29;   // root width
   localparam int XW = 38;   // CORDIC x/y width
   localparam int ZW = 32;   // CORDIC angle width, Q28 radians
   localparam int PW = 63;   // degree product width

   localparam logic signed [TW-1:0] ONE_Q28     = 34'sd268435456;
   localparam logic signed [ZW-1:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic signed [ZW-1:0] DEG_K       = 32'sd961263669;

   typedef logic signed [QW-1:0] quat_type;
   typedef logic signed [AW-1:0] angle_type;

   typedef struct packed {
      logic signed [TW-1:0] sr;
      logic signed [TW-1:0] cr;
      logic signed [TW-1:0] sy;
      logic signed [TW-1:0] cy;
   } terms_type;

   // arctangent of 2^-i in Q28 radians, rounded to nearest
   function automatic logic [ZW-1:0] atan_q28(input logic [4:0] i);
      logic [ZW-1:0] r;
      case (i)
         5'd0:    r = 32'd210828714;
         5'd1:    r = 32'd124459457;
         5'd2:    r = 32'd65760959;
         5'd3:    r = 32'd33381290;
         5'd4:    r = 32'd16755422;
         5'd5:    r = 32'd8385879;
         5'd6:    r = 32'd4193963;
         5'd7:    r = 32'd2097109;
         5'd8:    r = 32'd1048571;
         5'd9:    r = 32'd524287;
         5'd10:   r = 32'd262144;
         5'd11:   r = 32'd131072;
         5'd12:   r = 32'd65536;
         5'd13:   r = 32'd32768;
         5'd14:   r = 32'd16384;
         5'd15:   r = 32'd8192;
         5'd16:   r = 32'd4096;
         5'd17:   r = 32'd2048;
         5'd18:   r = 32'd1024;
         5'd19:   r = 32'd512;
         5'd20:   r = 32'd256;
         5'd21:   r = 32'd128;
         5'd22:   r = 32'd64;
         5'd23:   r = 32'd32;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Unit quaternion in Q1.14 to roll, pitch and yaw (ZYX), fully pipelined.
// ----------------------------------------------------------------------------
//  channel | ports                                 | handshake
//  --------+---------------------------------------+------------------
//  req     | req_qw req_qx req_qy req_qz           | req_valid/req_stall
//  rsp     | rsp_roll rsp_pitch rsp_yaw            | rsp_valid/rsp_stall
//          | rsp_pitch_clamped                     |
//  csr     | csr_angle_in_degrees                  | csr_valid/csr_ready
//
//  One word enters per cycle unless rsp is stalled; each word passes through
//  products, sums, 29 root stages, pre-rotation, one CORDIC stage per
//  iteration, the degree multiply and the rounding stage.
//  Reset clears every valid bit and selects radians.
//  A stalled result freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  q2e_pkg::quat_type   req_qw,
   input  q2e_pkg::quat_type   req_qx,
   input  q2e_pkg::quat_type   req_qy,
   input  q2e_pkg::quat_type   req_qz,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output q2e_pkg::angle_type  rsp_roll,
   output q2e_pkg::angle_type  rsp_pitch,
   output q2e_pkg::angle_type  rsp_yaw,
   output logic                rsp_pitch_clamped,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_angle_in_degrees
);
   import q2e_pkg::*;

   localparam int N = CORDIC_ITERATIONS;

   logic advance;
   logic deg_ff;

   // configuration
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         deg_ff <= 1'b0;
      end else if (csr_valid) begin
         deg_ff <= csr_angle_in_degrees;
      end
   end

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // stage 1: products
   logic                 p1_valid_ff;
   logic signed [31:0]   wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, xz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wx_ff <= 32'(req_qw) * 32'(req_qx);
         yz_ff <= 32'(req_qy) * 32'(req_qz);
         xx_ff <= 32'(req_qx) * 32'(req_qx);
         yy_ff <= 32'(req_qy) * 32'(req_qy);
         wz_ff <= 32'(req_qw) * 32'(req_qz);
         xy_ff <= 32'(req_qx) * 32'(req_qy);
         zz_ff <= 32'(req_qz) * 32'(req_qz);
         wy_ff <= 32'(req_qw) * 32'(req_qy);
         xz_ff <= 32'(req_qx) * 32'(req_qz);
      end
   end

   // stage 2: sums, clamp, root operands (root pipeline index 0)
   logic                 sq_valid_ff [RW+1];
   logic                 sq_flag_ff  [RW+1];
   terms_type            sq_terms_ff [RW+1];
   logic [RW-1:0]        sq_ra_ff    [RW+1];
   logic [RW-1:0]        sq_rb_ff    [RW+1];
   logic [VW-1:0]        sq_rema_ff  [RW+1];
   logic [VW-1:0]        sq_remb_ff  [RW+1];

   logic signed [32:0]   sum_sr, sum_cr, sum_sy, sum_cy, sum_s;
   logic signed [TW-1:0] s_raw, s_cl, s_pa, s_pb;
   terms_type            terms_in;
   logic                 flag_in;

   always_comb begin
      sum_sr = 33'(wx_ff) + 33'(yz_ff);
      sum_cr = 33'(xx_ff) + 33'(yy_ff);
      sum_sy = 33'(wz_ff) + 33'(xy_ff);
      sum_cy = 33'(yy_ff) + 33'(zz_ff);
      sum_s  = 33'(wy_ff) - 33'(xz_ff);
      terms_in.sr = {sum_sr, 1'b0};
      terms_in.cr = ONE_Q28 - {sum_cr, 1'b0};
      terms_in.sy = {sum_sy, 1'b0};
      terms_in.cy = ONE_Q28 - {sum_cy, 1'b0};
      s_raw   = {sum_s, 1'b0};
      flag_in = 1'b0;
      s_cl    = s_raw;
      if (s_raw > ONE_Q28) begin
         s_cl    = ONE_Q28;
         flag_in = 1'b1;
      end else if (s_raw < -ONE_Q28) begin
         s_cl    = -ONE_Q28;
         flag_in = 1'b1;
      end
      s_pa = ONE_Q28 + s_cl;
      s_pb = ONE_Q28 - s_cl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         sq_valid_ff[0] <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_flag_ff[0]  <= flag_in;
         sq_terms_ff[0] <= terms_in;
         sq_ra_ff[0]    <= '0;
         sq_rb_ff[0]    <= '0;
         sq_rema_ff[0]  <= {s_pa[29:0], 28'd0};
         sq_remb_ff[0]  <= {s_pb[29:0], 28'd0};
      end
   end

   // root stages: one result bit each, most significant first
   for (genvar j = 0; j < RW; j++) begin : g_root
      localparam int K = RW - 1 - j;
      logic [VW+1:0] trial_a, trial_b;
      logic          take_a, take_b;

      assign trial_a = ((VW+2)'(sq_ra_ff[j]) << (K + 1)) + ((VW+2)'(1) << (2 * K));
      assign trial_b = ((VW+2)'(sq_rb_ff[j]) << (K + 1)) + ((VW+2)'(1) << (2 * K));
      assign take_a  = (VW+2)'(sq_rema_ff[j]) >= trial_a;
      assign take_b  = (VW+2)'(sq_remb_ff[j]) >= trial_b;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[j+1] <= 1'b0;
         end else if (advance) begin
            sq_valid_ff[j+1] <= sq_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            sq_flag_ff[j+1]  <= sq_flag_ff[j];
            sq_terms_ff[j+1] <= sq_terms_ff[j];
            sq_ra_ff[j+1]    <= take_a ? (sq_ra_ff[j] | (RW'(1) << K)) : sq_ra_ff[j];
            sq_rb_ff[j+1]    <= take_b ? (sq_rb_ff[j] | (RW'(1) << K)) : sq_rb_ff[j];
            sq_rema_ff[j+1]  <= take_a ? VW'((VW+2)'(sq_rema_ff[j]) - trial_a)
                                       : sq_rema_ff[j];
            sq_remb_ff[j+1]  <= take_b ? VW'((VW+2)'(sq_remb_ff[j]) - trial_b)
                                       : sq_remb_ff[j];
         end
      end
   end

   // CORDIC lanes: 0 roll, 1 pitch, 2 yaw; index 0 holds the pre-rotation
   logic                 cv_ff    [N+1];
   logic                 cflag_ff [N+1];
   logic signed [XW-1:0] cx_ff    [3][N+1];
   logic signed [XW-1:0] cy_ff    [3][N+1];
   logic signed [ZW-1:0] cz_ff    [3][N+1];
   logic                 czero_ff [3][N+1];

   logic signed [XW-1:0] lane_x [3];
   logic signed [XW-1:0] lane_y [3];

   assign lane_y[0] = XW'(sq_terms_ff[RW].sr);
   assign lane_x[0] = XW'(sq_terms_ff[RW].cr);
   assign lane_y[1] = XW'(signed'({1'b0, sq_ra_ff[RW]}));
   assign lane_x[1] = XW'(signed'({1'b0, sq_rb_ff[RW]}));
   assign lane_y[2] = XW'(sq_terms_ff[RW].sy);
   assign lane_x[2] = XW'(sq_terms_ff[RW].cy);

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (advance) begin
         cv_ff[0] <= sq_valid_ff[RW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cflag_ff[0] <= sq_flag_ff[RW];
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      // pre-rotation: turn a vector with negative x a quarter turn
      always_ff @(posedge clock) begin
         if (advance) begin
            czero_ff[l][0] <= (lane_x[l] == '0) && (lane_y[l] == '0);
            if (lane_x[l] < 0) begin
               if (lane_y[l] >= 0) begin
                  cx_ff[l][0] <= lane_y[l];
                  cy_ff[l][0] <= -lane_x[l];
                  cz_ff[l][0] <= HALF_PI_Q28;
               end else begin
                  cx_ff[l][0] <= -lane_y[l];
                  cy_ff[l][0] <= lane_x[l];
                  cz_ff[l][0] <= -HALF_PI_Q28;
               end
            end else begin
               cx_ff[l][0] <= lane_x[l];
               cy_ff[l][0] <= lane_y[l];
               cz_ff[l][0] <= '0;
            end
         end
      end

      for (genvar i = 0; i < N; i++) begin : g_iter
         logic signed [XW-1:0] dx, dy;
         logic signed [ZW-1:0] da;

         assign dx = cy_ff[l][i] >>> i;
         assign dy = cx_ff[l][i] >>> i;
         assign da = signed'(atan_q28(5'(i)));

         always_ff @(posedge clock) begin
            if (advance) begin
               czero_ff[l][i+1] <= czero_ff[l][i];
               if (cy_ff[l][i] > 0) begin
                  cx_ff[l][i+1] <= cx_ff[l][i] + dx;
                  cy_ff[l][i+1] <= cy_ff[l][i] - dy;
                  cz_ff[l][i+1] <= cz_ff[l][i] + da;
               end else begin
                  cx_ff[l][i+1] <= cx_ff[l][i] - dx;
                  cy_ff[l][i+1] <= cy_ff[l][i] + dy;
                  cz_ff[l][i+1] <= cz_ff[l][i] - da;
               end
            end
         end
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_cvalid
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (advance) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            cflag_ff[i+1] <= cflag_ff[i];
         end
      end
   end

   // multiply stage: final angles and their degree products
   logic                 m_valid_ff, m_flag_ff;
   logic signed [ZW-1:0] m_z_ff    [3];
   logic signed [PW-1:0] m_prod_ff [3];
   logic signed [ZW-1:0] ang_in    [3];
   logic signed [ZW:0]   pitch_wide;

   always_comb begin
      ang_in[0]  = czero_ff[0][N] ? '0 : cz_ff[0][N];
      ang_in[2]  = czero_ff[2][N] ? '0 : cz_ff[2][N];
      pitch_wide = {(czero_ff[1][N] ? ZW'(0) : cz_ff[1][N]), 1'b0} - (ZW+1)'(HALF_PI_Q28);
      ang_in[1]  = ZW'(pitch_wide);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= cv_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_flag_ff <= cflag_ff[N];
         for (int l = 0; l < 3; l++) begin
            m_z_ff[l]    <= ang_in[l];
            m_prod_ff[l] <= PW'(ang_in[l]) * PW'(DEG_K);
         end
      end
   end

   // output stage: round, saturate, hold while stalled
   function automatic angle_type sat16(input logic signed [17:0] v);
      angle_type r;
      if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = AW'(v);
      end
      return r;
   endfunction

   logic signed [PW-1:0] deg_sum [3];
   logic signed [ZW:0]   rad_sum [3];
   angle_type            out_in  [3];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         deg_sum[l] = m_prod_ff[l] + (PW'(1) <<< 44);
         rad_sum[l] = (ZW+1)'(m_z_ff[l]) + (ZW+1)'(16384);
         out_in[l]  = deg_ff ? sat16(deg_sum[l][62:45]) : sat16(rad_sum[l][32:15]);
      end
   end

   logic      rsp_valid_ff, rsp_flag_ff;
   angle_type rsp_roll_ff, rsp_pitch_ff, rsp_yaw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_roll_ff  <= out_in[0];
         rsp_pitch_ff <= out_in[1];
         rsp_yaw_ff   <= out_in[2];
         rsp_flag_ff  <= m_flag_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_roll          = rsp_roll_ff;
   assign rsp_pitch         = rsp_pitch_ff;
   assign rsp_yaw           = rsp_yaw_ff;
   assign rsp_pitch_clamped = rsp_flag_ff;

endmodule
